[sv/mie_pkg.sv]
// ----------------------------------------------------------------------------
// mie_pkg: shared definitions for the modular inverse block
// Constants, status codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package mie_pkg;

	// default operand width and modulus after reset
	localparam int          MIE_DATA_WIDTH      = 31;
	localparam logic [63:0] MIE_DEFAULT_MODULUS = 64'd998244353;

	// result status codes
	localparam logic STATUS_OK             = 1'b0;
	localparam logic STATUS_NOT_INVERTIBLE = 1'b1;

	// register index of the modulus
	localparam logic REG_MODULUS = 1'b0;

	// commands from controller to datapath
	typedef struct packed {
		logic load_red;   // start reduction of the input value
		logic step;       // one divider iteration
		logic div_round;  // divisor is current remainder, else modulus
		logic setup;      // start the euclid loop, settle special cases
		logic update;     // close a round, start the next division
		logic finish;     // form the final inverse
		logic load_out;   // move result into the output register
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic last_step;  // divider on its final iteration
		logic rem_zero;   // divider remainder is zero
		logic special;    // modulus zero or one, or value reduces to zero
	} sts_t;

endpackage

[sv/modular_inverse_euclid.sv]
// ----------------------------------------------------------------------------
// modular_inverse_euclid: modular inverse by the extended euclidean algorithm
// Flow: reduction of the input value, then R euclid rounds, each round one
//   bit-serial division plus one update step, then a final correction;
//   special cases (modulus zero or one, value reducing to zero) skip the rounds.
// Throughput: one transaction at a time; the next is taken once the result
//   sits in the output register. Reset clears control and sets modulus to
//   998244353.
// ----------------------------------------------------------------------------
module modular_inverse_euclid #(
	parameter int DATA_WIDTH = mie_pkg::MIE_DATA_WIDTH,
	localparam int APB_DW    = (DATA_WIDTH > 32) ? 64 : 32,
	localparam int ADDR_W    = (APB_DW == 64) ? 4 : 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DATA_WIDTH-1:0] value,
	// output channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_WIDTH-1:0] inverse,
	output logic                  status,
	// configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [APB_DW-1:0]     pwdata,
	output logic [APB_DW-1:0]     prdata,
	output logic                  pready
);
	import mie_pkg::*;

	localparam logic [DATA_WIDTH-1:0] RST_MODULUS = MIE_DEFAULT_MODULUS[DATA_WIDTH-1:0];

	logic [DATA_WIDTH-1:0] modulus_q;
	logic                  reg_sel;
	cmd_t                  cmd;
	sts_t                  sts;

	// register decode
	assign pready  = 1'b1;
	assign reg_sel = (paddr[ADDR_W-1] == REG_MODULUS);

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= RST_MODULUS;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			modulus_q <= pwdata[DATA_WIDTH-1:0];
		end
	end

	// read back
	assign prdata = reg_sel ? APB_DW'(modulus_q) : '0;

	mie_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mie_dpath #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.value   (value),
		.modulus (modulus_q),
		.inverse (inverse),
		.status  (status)
	);

endmodule

[sv/mie_ctrl.sv]
// ----------------------------------------------------------------------------
// mie_ctrl: sequencer for the modular inverse block
// Steps the datapath through reduction, euclid rounds and final correction,
// and owns the input ready and output valid handshakes.
// ----------------------------------------------------------------------------
module mie_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  mie_pkg::sts_t sts,
	output mie_pkg::cmd_t cmd
);
	import mie_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_REDUCE = 3'd1;
	localparam logic [2:0] S_SETUP  = 3'd2;
	localparam logic [2:0] S_ROUND  = 3'd3;
	localparam logic [2:0] S_UPDATE = 3'd4;
	localparam logic [2:0] S_FINAL  = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_red = 1'b1;
					state_d      = S_REDUCE;
				end
			end
			S_REDUCE: begin
				cmd.step = 1'b1;
				if (sts.last_step) begin
					state_d = S_SETUP;
				end
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = sts.special ? S_DONE : S_ROUND;
			end
			S_ROUND: begin
				cmd.step      = 1'b1;
				cmd.div_round = 1'b1;
				if (sts.last_step) begin
					state_d = S_UPDATE;
				end
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = sts.rem_zero ? S_FINAL : S_ROUND;
			end
			S_FINAL: begin
				cmd.finish = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// an accepted transaction starts the reduction
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_REDUCE)
		else $error("accepted transaction did not start reduction");

	// a result only appears from the done state
	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("output valid rose outside done state");

	// the output register is never overwritten while still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("output register overwritten");

	// a finished round division always closes the round
	a_round_closes: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ROUND && sts.last_step |=> state_q == S_UPDATE)
		else $error("round division did not close");

endmodule

[sv/mie_dpath.sv]
// ----------------------------------------------------------------------------
// mie_dpath: datapath for the modular inverse block
// Bit-serial restoring divider with a shift-and-add coefficient product,
// euclid remainder and coefficient registers, and the output register.
// ----------------------------------------------------------------------------
module mie_dpath #(
	parameter int DATA_WIDTH = mie_pkg::MIE_DATA_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mie_pkg::cmd_t         cmd,
	output mie_pkg::sts_t         sts,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic [DATA_WIDTH-1:0] modulus,
	output logic [DATA_WIDTH-1:0] inverse,
	output logic                  status
);
	import mie_pkg::*;

	localparam int CNT_W = $clog2(DATA_WIDTH);

	logic [DATA_WIDTH-1:0] r_prev_q, r_cur_q, c_prev_q, c_cur_q;
	logic [DATA_WIDTH-1:0] rem_q, quo_q, acc_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  par_q;
	logic [DATA_WIDTH-1:0] res_q;
	logic                  flag_q;
	logic [DATA_WIDTH-1:0] inverse_q;
	logic                  status_q;

	logic [DATA_WIDTH-1:0] divisor;
	logic [DATA_WIDTH:0]   rem_shift;
	logic                  qbit;
	logic [DATA_WIDTH:0]   rem_sub;
	logic [DATA_WIDTH-1:0] acc_next;
	logic                  m_zero, m_one;
	logic [DATA_WIDTH-1:0] pos, neg;

	// divider iteration: shift in one dividend bit, compare and subtract
	assign divisor   = cmd.div_round ? r_cur_q : modulus;
	assign rem_shift = {rem_q, quo_q[DATA_WIDTH-1]};
	assign qbit      = (rem_shift >= {1'b0, divisor});
	assign rem_sub   = rem_shift - {1'b0, divisor};
	// quotient times coefficient built msb first
	assign acc_next  = {acc_q[DATA_WIDTH-2:0], 1'b0} + (qbit ? c_cur_q : '0);

	// status to the controller
	assign m_zero        = (modulus == '0);
	assign m_one         = (modulus == DATA_WIDTH'(1));
	assign sts.last_step = (cnt_q == CNT_W'(DATA_WIDTH - 1));
	assign sts.rem_zero  = (rem_q == '0);
	assign sts.special   = m_zero || m_one || (rem_q == '0);

	// sign correction of the final coefficient
	assign pos = (c_prev_q >= modulus) ? c_prev_q - modulus : c_prev_q;
	assign neg = (pos == '0) ? '0 : modulus - pos;

	// iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load_red || cmd.setup || cmd.update) begin
			cnt_q <= '0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// divider and euclid registers
	always_ff @(posedge clk) begin
		if (cmd.load_red) begin
			quo_q <= value;
			rem_q <= '0;
			acc_q <= '0;
		end else if (cmd.step) begin
			quo_q <= {quo_q[DATA_WIDTH-2:0], qbit};
			rem_q <= qbit ? rem_sub[DATA_WIDTH-1:0] : rem_shift[DATA_WIDTH-1:0];
			acc_q <= acc_next;
		end else if (cmd.setup) begin
			r_prev_q <= modulus;
			r_cur_q  <= rem_q;
			c_prev_q <= '0;
			c_cur_q  <= DATA_WIDTH'(1);
			par_q    <= 1'b0;
			quo_q    <= modulus;
			rem_q    <= '0;
			acc_q    <= '0;
			res_q    <= '0;
			flag_q   <= m_zero || (!m_one && (rem_q == '0));
		end else if (cmd.update) begin
			r_prev_q <= r_cur_q;
			r_cur_q  <= rem_q;
			c_prev_q <= c_cur_q;
			c_cur_q  <= c_prev_q + acc_q;
			par_q    <= ~par_q;
			quo_q    <= r_cur_q;
			rem_q    <= '0;
			acc_q    <= '0;
		end else if (cmd.finish) begin
			if (r_prev_q != DATA_WIDTH'(1)) begin
				res_q  <= '0;
				flag_q <= STATUS_NOT_INVERTIBLE;
			end else begin
				res_q  <= par_q ? pos : neg;
				flag_q <= STATUS_OK;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			inverse_q <= res_q;
			status_q  <= flag_q;
		end
	end

	assign inverse = inverse_q;
	assign status  = status_q;

endmodule
